FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions sampled on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hw/rtl/csbc_pkg.sv
// ----------------------------------------------------------------------------
// Clock set button controller package
// Button codes, screen codes, mode encoding and time limits.
// ----------------------------------------------------------------------------
package csbc_pkg;

   // Button codes carried on the request opcode.
   localparam logic [1:0] OP_MODE   = 2'd0;
   localparam logic [1:0] OP_UP     = 2'd1;
   localparam logic [1:0] OP_DOWN   = 2'd2;
   localparam logic [1:0] OP_CHANGE = 2'd3;

   // Screen request codes.
   localparam logic [2:0] SCREEN_NONE     = 3'd0;
   localparam logic [2:0] SCREEN_HOME     = 3'd1;
   localparam logic [2:0] SCREEN_MENU     = 3'd2;
   localparam logic [2:0] SCREEN_SET_TIME = 3'd3;
   localparam logic [2:0] SCREEN_SET_ALRM = 3'd4;

   // Mode codes as reported on the response.
   localparam logic [1:0] MODE_CODE_HOME = 2'd0;
   localparam logic [1:0] MODE_CODE_MENU = 2'd1;
   localparam logic [1:0] MODE_CODE_SET  = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd200;
   localparam logic [5:0]  MINUTE_MAX     = 6'd59;
   localparam logic [4:0]  HOUR_MAX       = 5'd23;

   typedef enum logic [2:0] {
      ST_IDLE_SCREEN = 3'b001,
      ST_SETUP_LIST  = 3'b010,
      ST_TIME_EDIT   = 3'b100
   } mode_type;

   function automatic logic [1:0] mode_code(input mode_type mode);
      logic [1:0] code;
      unique case (mode)
         ST_IDLE_SCREEN: code = MODE_CODE_HOME;
         ST_SETUP_LIST:  code = MODE_CODE_MENU;
         ST_TIME_EDIT:   code = MODE_CODE_SET;
         default:        code = MODE_CODE_HOME;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/clock_set_button_controller.sv
// ----------------------------------------------------------------------------
// Clock set button controller
// Path: an accepted request moves from the input register to the response register when the work stage advances.
// Throughput: one request per cycle unless stalled; the debounce subtract and compare is the longest path.
// Reset: synchronous, active high; mode home, time 00:00, press times zero, debounce 200.
// ----------------------------------------------------------------------------
module clock_set_button_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [1:0]  rsp_mode_now,
   output logic        rsp_select_now,
   output logic [4:0]  rsp_hour_now,
   output logic [5:0]  rsp_minute_now,
   output logic [2:0]  rsp_screen_request,
   output logic        rsp_wake,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import csbc_pkg::*;

   // The block is a two register pipeline. The input register captures a
   // request; while it holds it, the press is checked against its button's
   // lockout, and when it moves on the clock state is updated and the response
   // register is loaded. Since the state is read and written in that same cycle,
   // back-to-back requests always see the state left by the previous one.

   logic        in_valid_ff;
   logic [1:0]  in_opcode_ff;
   logic [31:0] in_now_ff;

   logic [15:0] debounce_ff;
   mode_type    mode_ff, mode_in;
   logic        select_ff, select_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [31:0] last_ff [4];

   logic        out_valid_ff;
   logic        out_accepted_ff;
   logic [1:0]  out_mode_ff;
   logic        out_select_ff;
   logic [4:0]  out_hour_ff;
   logic [5:0]  out_minute_ff;
   logic [2:0]  out_screen_ff, screen_in;
   logic        out_wake_ff, wake_in;

   logic        advance;
   logic [31:0] elapsed;
   logic        pass;

   // The work stage moves when it holds a request and the response register
   // is empty or being drained. The input register is free whenever its
   // content moves on this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         in_opcode_ff <= req_opcode;
         in_now_ff    <= req_now_ms;
      end
   end

   // Debounce register; the user must write it only while the block is idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_write_enable) begin
         debounce_ff <= csr_write_data;
      end
   end

   // Lockout check: the wrapped time since the button's last accepted press
   // must be strictly larger than the debounce time.
   assign elapsed = in_now_ff - last_ff[in_opcode_ff];
   assign pass    = elapsed > {16'd0, debounce_ff};

   // Next state and the screen and wake flags for one press. A rejected
   // press leaves everything as it is and reports the current state.
   always_comb begin
      mode_in   = mode_ff;
      select_in = select_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      screen_in = SCREEN_NONE;
      wake_in   = 1'b0;
      if (pass) begin
         unique case (in_opcode_ff)
            OP_MODE: begin
               unique case (mode_ff)
                  ST_IDLE_SCREEN: begin
                     mode_in   = ST_SETUP_LIST;
                     screen_in = SCREEN_MENU;
                  end
                  ST_SETUP_LIST: begin
                     mode_in   = ST_TIME_EDIT;
                     screen_in = select_ff ? SCREEN_SET_ALRM : SCREEN_SET_TIME;
                  end
                  ST_TIME_EDIT: begin
                     mode_in   = ST_IDLE_SCREEN;
                     screen_in = SCREEN_HOME;
                  end
                  default: begin
                     mode_in   = mode_ff;
                     screen_in = SCREEN_NONE;
                  end
               endcase
            end
            OP_UP: begin
               wake_in = 1'b1;
               if (mode_ff == ST_TIME_EDIT) begin
                  if (!select_ff) begin
                     minute_in = (minute_ff >= MINUTE_MAX) ? 6'd0 : minute_ff + 6'd1;
                  end else begin
                     hour_in = (hour_ff >= HOUR_MAX) ? 5'd0 : hour_ff + 5'd1;
                  end
               end
            end
            OP_DOWN: begin
               wake_in = 1'b1;
               if (mode_ff == ST_TIME_EDIT) begin
                  if (!select_ff) begin
                     minute_in = (minute_ff == 6'd0 || minute_ff > MINUTE_MAX) ?
                                 MINUTE_MAX : minute_ff - 6'd1;
                  end else begin
                     hour_in = (hour_ff == 5'd0 || hour_ff > HOUR_MAX) ?
                               HOUR_MAX : hour_ff - 5'd1;
                  end
               end
            end
            OP_CHANGE: begin
               wake_in   = 1'b1;
               select_in = !select_ff;
            end
            default: begin
               wake_in = 1'b0;
            end
         endcase
      end
   end

   // Clock state and the per-button press times.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ST_IDLE_SCREEN;
         select_ff <= 1'b0;
         hour_ff   <= 5'd0;
         minute_ff <= 6'd0;
         for (int i = 0; i < 4; i++) begin
            last_ff[i] <= 32'd0;
         end
      end else if (advance) begin
         mode_ff   <= mode_in;
         select_ff <= select_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         if (pass) begin
            last_ff[in_opcode_ff] <= in_now_ff;
         end
      end
   end

   // Response register. It holds its content while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_accepted_ff <= pass;
         out_mode_ff     <= mode_code(mode_in);
         out_select_ff   <= select_in;
         out_hour_ff     <= hour_in;
         out_minute_ff   <= minute_in;
         out_screen_ff   <= screen_in;
         out_wake_ff     <= wake_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_accepted       = out_accepted_ff;
   assign rsp_mode_now       = out_mode_ff;
   assign rsp_select_now     = out_select_ff;
   assign rsp_hour_now       = out_hour_ff;
   assign rsp_minute_now     = out_minute_ff;
   assign rsp_screen_request = out_screen_ff;
   assign rsp_wake           = out_wake_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`include "assert_macros.svh"

   // A screen request only comes from an accepted mode press, which never wakes.
   `ASSERT_CLK(a_screen_only_on_mode, (rsp_valid && rsp_screen_request != SCREEN_NONE) |-> (rsp_accepted && !rsp_wake), "screen request without an accepted mode press")

   // The stored time never leaves its range.
   `ASSERT_CLK(a_time_in_range, (hour_ff <= HOUR_MAX) && (minute_ff <= MINUTE_MAX), "hour or minute out of range")

   // A rejected press changes no state.
   `ASSERT_CLK(a_reject_keeps_state, (advance && !pass) |=> (mode_ff == $past(mode_ff) && select_ff == $past(select_ff) && hour_ff == $past(hour_ff) && minute_ff == $past(minute_ff)), "rejected press changed the state")

   // Nothing is presented right after a reset.
   `ASSERT_CLK_ALWAYS(a_quiet_after_reset, $past(reset) |-> !rsp_valid, "response valid after reset")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Clock set button controller testbench
// Drives button press requests through the request channel and checks every
// response against a scripted value or a cycle-free predictor in this bench.
// A scripted opening covers the lockout boundaries, every button, the mode
// cycle and the minute and hour wrap. Random phases follow under several
// debounce settings and idle patterns, including one long response hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import csbc_pkg::*;

   // One response as the block reports it.
   typedef struct packed {
      logic       accepted;
      logic [1:0] mode;
      logic       select;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [2:0] screen;
      logic       wake;
   } readout_type;

   // One scripted press. When typed is set, the response is compared with the
   // value written here. Otherwise the predictor supplies it.
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] stamp;
      logic        typed;
      readout_type want;
   } press_row_type;

   localparam int SCRIPT_ROWS  = 23;
   localparam int PHASE_PRESSES = 188;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 120;

   // Clock, reset and every input of the block start at a known value.
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [1:0]  req_opcode       = OP_MODE;
   logic [31:0] req_now_ms       = '0;
   logic        rsp_stall        = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data   = '0;

   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_accepted;
   logic [1:0]  rsp_mode_now;
   logic        rsp_select_now;
   logic [4:0]  rsp_hour_now;
   logic [5:0]  rsp_minute_now;
   logic [2:0]  rsp_screen_request;
   logic        rsp_wake;

   // Predictor state, at its reset values.
   logic [15:0] debounce_q = DEBOUNCE_RESET;
   logic [1:0]  mode_q     = MODE_CODE_HOME;
   logic        select_q   = 1'b0;
   logic [4:0]  hour_q     = '0;
   logic [5:0]  minute_q   = '0;
   logic [31:0] press_stamp [4] = '{default: '0};

   // Responses still owed by the block, oldest first.
   readout_type readout_queue [$];

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int          rsp_hold_left     = 0;
   int          mismatch_count    = 0;
   int          quiet_cycles      = 0;

   // The scripted opening runs with the reset debounce of 200 ms. The rows
   // walk the lockout edges (exactly the debounce is rejected, one more is
   // accepted), the full mode cycle with both set screens, minute and hour
   // wrap in both directions, an up press outside set time, and a lockout
   // measured across the wrap of the millisecond counter.
   press_row_type press_script [SCRIPT_ROWS] = '{
      '{OP_MODE,   32'd100,  1'b1,
        '{1'b0, MODE_CODE_HOME, 1'b0, 5'd0,  6'd0,  SCREEN_NONE,     1'b0}},
      '{OP_MODE,   32'd200,  1'b1,
        '{1'b0, MODE_CODE_HOME, 1'b0, 5'd0,  6'd0,  SCREEN_NONE,     1'b0}},
      '{OP_MODE,   32'd201,  1'b1,
        '{1'b1, MODE_CODE_MENU, 1'b0, 5'd0,  6'd0,  SCREEN_MENU,     1'b0}},
      '{OP_UP,     32'd300,  1'b1,
        '{1'b1, MODE_CODE_MENU, 1'b0, 5'd0,  6'd0,  SCREEN_NONE,     1'b1}},
      '{OP_MODE,   32'd401,  1'b1,
        '{1'b0, MODE_CODE_MENU, 1'b0, 5'd0,  6'd0,  SCREEN_NONE,     1'b0}},
      '{OP_MODE,   32'd402,  1'b1,
        '{1'b1, MODE_CODE_SET,  1'b0, 5'd0,  6'd0,  SCREEN_SET_TIME, 1'b0}},
      '{OP_DOWN,   32'd500,  1'b1,
        '{1'b1, MODE_CODE_SET,  1'b0, 5'd0,  6'd59, SCREEN_NONE,     1'b1}},
      '{OP_UP,     32'd701,  1'b1,
        '{1'b1, MODE_CODE_SET,  1'b0, 5'd0,  6'd0,  SCREEN_NONE,     1'b1}},
      '{OP_UP,     32'd800,  1'b1,
        '{1'b0, MODE_CODE_SET,  1'b0, 5'd0,  6'd0,  SCREEN_NONE,     1'b0}},
      '{OP_CHANGE, 32'd900,  1'b1,
        '{1'b1, MODE_CODE_SET,  1'b1, 5'd0,  6'd0,  SCREEN_NONE,     1'b1}},
      '{OP_DOWN,   32'd1000, 1'b1,
        '{1'b1, MODE_CODE_SET,  1'b1, 5'd23, 6'd0,  SCREEN_NONE,     1'b1}},
      '{OP_UP,     32'd1200, 1'b1,
        '{1'b1, MODE_CODE_SET,  1'b1, 5'd0,  6'd0,  SCREEN_NONE,     1'b1}},
      '{OP_CHANGE, 32'd1301, 1'b1,
        '{1'b1, MODE_CODE_SET,  1'b0, 5'd0,  6'd0,  SCREEN_NONE,     1'b1}},
      '{OP_MODE,   32'd1500, 1'b1,
        '{1'b1, MODE_CODE_HOME, 1'b0, 5'd0,  6'd0,  SCREEN_HOME,     1'b0}},
      '{OP_MODE,   32'd1800, 1'b1,
        '{1'b1, MODE_CODE_MENU, 1'b0, 5'd0,  6'd0,  SCREEN_MENU,     1'b0}},
      '{OP_CHANGE, 32'd1900, 1'b1,
        '{1'b1, MODE_CODE_MENU, 1'b1, 5'd0,  6'd0,  SCREEN_NONE,     1'b1}},
      '{OP_MODE,   32'd2100, 1'b1,
        '{1'b1, MODE_CODE_SET,  1'b1, 5'd0,  6'd0,  SCREEN_SET_ALRM, 1'b0}},
      '{OP_UP,     32'd2200, 1'b0, '0},
      '{OP_DOWN,   32'd2201, 1'b0, '0},
      '{OP_MODE,   32'hFFFF_FFF0, 1'b1,
        '{1'b1, MODE_CODE_HOME, 1'b1, 5'd0,  6'd0,  SCREEN_HOME,     1'b0}},
      '{OP_MODE,   32'h0000_0010, 1'b1,
        '{1'b0, MODE_CODE_HOME, 1'b1, 5'd0,  6'd0,  SCREEN_NONE,     1'b0}},
      '{OP_MODE,   32'h0000_00B8, 1'b1,
        '{1'b0, MODE_CODE_HOME, 1'b1, 5'd0,  6'd0,  SCREEN_NONE,     1'b0}},
      '{OP_MODE,   32'h0000_00B9, 1'b1,
        '{1'b1, MODE_CODE_MENU, 1'b1, 5'd0,  6'd0,  SCREEN_MENU,     1'b0}}
   };

   clock_set_button_controller u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_mode_now       (rsp_mode_now),
      .rsp_select_now     (rsp_select_now),
      .rsp_hour_now       (rsp_hour_now),
      .rsp_minute_now     (rsp_minute_now),
      .rsp_screen_request (rsp_screen_request),
      .rsp_wake           (rsp_wake),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5ns clock = ~clock;

   // Predictor: applies one accepted request to the bench's copy of the
   // controller state and returns the response the block should give.
   task automatic apply_press(input logic [1:0] op, input logic [31:0] stamp,
                              output readout_type r);
      logic [31:0] gap;
      gap = stamp - press_stamp[op];
      r = '0;
      // The lockout is per button and uses wrapping subtraction, so a press
      // just after the counter wraps is still measured correctly.
      if (gap > {16'd0, debounce_q}) begin
         r.accepted = 1'b1;
         press_stamp[op] = stamp;
         case (op)
            OP_MODE: begin
               case (mode_q)
                  MODE_CODE_HOME: begin
                     mode_q = MODE_CODE_MENU;
                     r.screen = SCREEN_MENU;
                  end
                  MODE_CODE_MENU: begin
                     mode_q = MODE_CODE_SET;
                     r.screen = select_q ? SCREEN_SET_ALRM : SCREEN_SET_TIME;
                  end
                  MODE_CODE_SET: begin
                     mode_q = MODE_CODE_HOME;
                     r.screen = SCREEN_HOME;
                  end
                  default: ;
               endcase
            end
            OP_CHANGE: begin
               select_q = ~select_q;
               r.wake = 1'b1;
            end
            default: begin
               // Up and down only move the time in set mode, but they wake
               // the display in every mode.
               if (mode_q == MODE_CODE_SET) begin
                  if (!select_q) begin
                     if (op == OP_UP)
                        minute_q = (minute_q >= MINUTE_MAX) ? 6'd0 : minute_q + 6'd1;
                     else
                        minute_q = (minute_q == 6'd0 || minute_q > MINUTE_MAX) ?
                                   MINUTE_MAX : minute_q - 6'd1;
                  end else begin
                     if (op == OP_UP)
                        hour_q = (hour_q >= HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
                     else
                        hour_q = (hour_q == 5'd0 || hour_q > HOUR_MAX) ?
                                 HOUR_MAX : hour_q - 5'd1;
                  end
               end
               r.wake = 1'b1;
            end
         endcase
      end
      r.mode   = mode_q;
      r.select = select_q;
      r.hour   = hour_q;
      r.minute = minute_q;
   endtask

   // Offers one request, with random idle cycles ahead of it, and holds it
   // until the block takes it. The expectation is queued at the accepting
   // edge; valid stays high on return so back-to-back requests need no
   // second assignment in the same step.
   task automatic send_press(input logic [1:0] op, input logic [31:0] stamp,
                             input logic typed, input readout_type want);
      readout_type predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_now_ms <= stamp;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      apply_press(op, stamp, predicted);
      readout_queue.push_back(typed ? want : predicted);
   endtask

   // Waits until every owed response has come back, plus a short margin.
   task automatic settle();
      req_valid <= 1'b0;
      while (readout_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_debounce(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      debounce_q = value;
   endtask

   // One random phase. Timestamps are placed relative to the last accepted
   // press of the chosen button, so most requests land on or near the
   // lockout edge; a tenth jump anywhere in the 32-bit range, which also
   // carries the counter across its wrap.
   task automatic run_phase(input logic write_cfg, input logic [15:0] cfg,
                            input int unsigned send_pct, input int unsigned rcv_pct,
                            input int hold);
      int unsigned pick;
      int unsigned span;
      logic [1:0]  op;
      logic [31:0] stamp;
      if (write_cfg) begin
         settle();
         write_debounce(cfg);
      end
      sender_idle_pct   = send_pct;
      receiver_idle_pct = rcv_pct;
      rsp_hold_left     = hold;
      for (int n = 0; n < PHASE_PRESSES; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2)
            op = OP_MODE;
         else if (pick < 5)
            op = OP_UP;
         else if (pick < 8)
            op = OP_DOWN;
         else
            op = OP_CHANGE;
         span = 32'(debounce_q);
         pick = $urandom_range(0, 99);
         if (pick < 15)
            stamp = press_stamp[op] + span;
         else if (pick < 30)
            stamp = press_stamp[op] + span + 1;
         else if (pick < 60)
            stamp = press_stamp[op] + $urandom_range(0, span);
         else if (pick < 90)
            stamp = press_stamp[op] + span + 1 + $urandom_range(0, 2 * span + 16);
         else
            stamp = $urandom();
         send_press(op, stamp, 1'b0, '0);
      end
   endtask

   // Receiver: stalls at the current random rate, or without a break while a
   // hold-off is running. The hold-off is counted down here, in cycles.
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Response checker and watchdog. Outputs are sampled at the edge, before
   // the block's registers move, so nothing here depends on event order.
   always @(posedge clock) begin
      readout_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (readout_queue.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = readout_queue.pop_front();
               check_field("accepted",       32'(want.accepted), 32'(rsp_accepted));
               check_field("mode_now",       32'(want.mode),     32'(rsp_mode_now));
               check_field("select_now",     32'(want.select),   32'(rsp_select_now));
               check_field("hour_now",       32'(want.hour),     32'(rsp_hour_now));
               check_field("minute_now",     32'(want.minute),   32'(rsp_minute_now));
               check_field("screen_request", 32'(want.screen),   32'(rsp_screen_request));
               check_field("wake",           32'(want.wake),     32'(rsp_wake));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("clock_set_button_controller regression: fail");
            $finish;
         end
      end
   end

   // Main sequence: reset, the scripted opening, then six random phases.
   // The first two phases run with a slow sender and a very slow receiver,
   // the next two the other way round, and the last two with no idling.
   // The fifth phase opens with a long response hold-off while the sender
   // keeps offering, so the block backs up and stalls its request side.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 23;
      receiver_idle_pct = 86;
      for (int i = 0; i < SCRIPT_ROWS; i++)
         send_press(press_script[i].op, press_script[i].stamp,
                    press_script[i].typed, press_script[i].want);

      // The first phase keeps the reset debounce; every later one rewrites it.
      run_phase(1'b0, 16'd0, 23, 86, 0);
      run_phase(1'b1, 16'hFFFF, 23, 86, 0);
      run_phase(1'b1, 16'd0, 86, 23, 0);
      run_phase(1'b1, 16'd1, 86, 23, 0);
      run_phase(1'b1, 16'($urandom_range(2, 65534)), 0, 0, HOLD_CYCLES);
      run_phase(1'b1, DEBOUNCE_RESET, 0, 0, 0);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("clock_set_button_controller regression: pass");
      else
         $display("clock_set_button_controller regression: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/csbc_pkg.sv
hw/rtl/clock_set_button_controller.sv
verif/tb_top.sv
